>>> rtl/qs_pkg.sv
// shared types, constants and tables for the quaternion interpolation block
// no dependencies; every other file refers to this package by scoped names
package qs_pkg;

  // cordic depth and arctangent table (q.30 radians)
  localparam int TRIG_STAGES  = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam logic [29:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
    30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
    30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
  };
  localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sh026DD3B6A;

  // square root unit: radicand and root widths, one root bit per stage
  localparam int RAD_W     = 62;
  localparam int SQRT_BITS = 31;

  // rounding divider: signed numerator, unsigned divisor, saturating quotient
  localparam int NUM_W      = 52;
  localparam int DEN_W      = 31;
  localparam int DIV_QBITS  = 17;
  localparam int DIV_STAGES = DIV_QBITS + 1;
  localparam int DIV_REM_W  = NUM_W + 1;

  // queue between the classifier and the arithmetic back end
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  // configuration register map
  localparam logic       CFG_EPSILON = 1'b0;
  localparam logic [15:0] EPS_RESET  = 16'd168;

  // one classified word handed from front to back
  typedef struct packed {
    logic [3:0][15:0] p;     // start quaternion
    logic [3:0][16:0] qn;    // target, negated when the dot is negative
    logic [16:0]      t;     // saturated fraction
    logic [3:0][24:0] l;     // lerp, q.22
    logic [29:0]      d30;   // |dot| in q.30
    logic [RAD_W-1:0] rad;   // radicand for the shared root
    logic             lin;   // linear path
    logic             norm;  // linear path with normalisation
  } item_t;

endpackage

>>> rtl/quaternion_slerp_top.sv
// quaternion interpolation, spherical with a normalised linear fallback
//
// input stream: one word per request, two q1.14 quaternions and a q1.16
// fraction (values above one are clamped to one). output stream: one word per
// request, in order, the q1.14 result with tuser set when the linear path ran.
// apb port: register 0 at byte address 0 holds epsilon, the skip tolerance on
// the squared norm; pready is always high.
//
// a new request is taken every cycle while in_tready is high. from acceptance
// to the result word being offered, a request passes a four stage classifier,
// the queue, a 31 stage square root, two cordic chains with the angle scaling
// stage between them, the weight and select stages, an 18 stage divider and
// the output register. when the receiver stalls the back pipeline holds and
// the classifier accepts until its four entry queue fills, then in_tready drops.
// synchronous reset empties the pipelines and the queue and sets epsilon to 168.
//
// uses qs_pkg, qs_front, qs_queue, qs_back
module quaternion_slerp_top (
  input  logic         clk,
  input  logic         rst_n,
  // from_x, from_y, from_z, from_w, to_x, to_y, to_z, to_w, fraction, zero pad
  input  logic [151:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // res_x, res_y, res_z, res_w
  output logic [63:0]  out_tdata,
  // used_linear
  output logic         out_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [15:0]   eps_r;
  logic          f_en;
  logic          push_valid;
  qs_pkg::item_t push_item;
  logic          q_full, q_valid, q_pop;
  qs_pkg::item_t q_head;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == qs_pkg::CFG_EPSILON) ? {16'b0, eps_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= qs_pkg::EPS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == qs_pkg::CFG_EPSILON) begin
      eps_r <= cfg_pwdata[15:0];
    end
  end

  // front stalls only when its last word cannot enter the queue
  assign f_en      = !(push_valid && q_full);
  assign in_tready = f_en;

  qs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (f_en),
    .in_valid   (in_tvalid),
    .in_data    (in_tdata),
    .eps        (eps_r),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  qs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid && !q_full),
    .push_item (push_item),
    .pop       (q_pop),
    .valid     (q_valid),
    .full      (q_full),
    .head      (q_head)
  );

  qs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_head),
    .q_pop      (q_pop),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> rtl/qs_front.sv
// front end: accepts words, forms the dot product, the lerp and the radicand
// uses qs_pkg; feeds qs_queue
module qs_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [151:0]    in_data,
  input  logic [15:0]     eps,
  output logic            push_valid,
  output qs_pkg::item_t   push_item
);

  // stage 1 registers
  logic                v1_r;
  logic signed [15:0]  p1_r  [4];
  logic signed [15:0]  q1_r  [4];
  logic [16:0]         t1_r;
  logic signed [31:0]  pq1_r [4];
  logic signed [33:0]  pa1_r [4];
  logic signed [33:0]  qt1_r [4];
  // stage 2 registers
  logic                v2_r;
  logic signed [15:0]  p2_r   [4];
  logic signed [16:0]  qn2_r  [4];
  logic [16:0]         t2_r;
  logic signed [33:0]  pa2_r  [4];
  logic signed [34:0]  qtn2_r [4];
  logic [32:0]         dabs2_r;
  // stage 3 registers
  logic                v3_r;
  logic signed [15:0]  p3_r  [4];
  logic signed [16:0]  qn3_r [4];
  logic [16:0]         t3_r;
  logic signed [24:0]  l3_r  [4];
  logic                lin3_r;
  logic [29:0]         d30_3_r;
  // stage 4 registers
  logic                v4_r;
  logic signed [15:0]  p4_r  [4];
  logic signed [16:0]  qn4_r [4];
  logic [16:0]         t4_r;
  logic signed [24:0]  l4_r  [4];
  logic                lin4_r;
  logic [29:0]         d30_4_r;
  logic [47:0]         lsq4_r [4];
  logic [59:0]         dsq4_r;

  // stage 1: fraction clamp and all input products
  logic [16:0] t_in, t_c, om;
  logic signed [15:0] pk [4];
  logic signed [15:0] qk [4];
  always_comb begin
    t_in = in_data[144:128];
    t_c  = (t_in > 17'd65536) ? 17'd65536 : t_in;
    om   = 17'd65536 - t_c;
    for (int k = 0; k < 4; k++) begin
      pk[k] = in_data[16*k +: 16];
      qk[k] = in_data[64 + 16*k +: 16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r <= t_c;
      for (int k = 0; k < 4; k++) begin
        p1_r[k]  <= pk[k];
        q1_r[k]  <= qk[k];
        pq1_r[k] <= pk[k] * qk[k];
        pa1_r[k] <= pk[k] * $signed({1'b0, om});
        qt1_r[k] <= qk[k] * $signed({1'b0, t_c});
      end
    end
  end

  // stage 2: dot sum, fold to the short arc
  logic signed [33:0] dot;
  logic               neg;
  always_comb begin
    dot = 34'(pq1_r[0]) + 34'(pq1_r[1]) + 34'(pq1_r[2]) + 34'(pq1_r[3]);
    neg = dot[33];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_r    <= t1_r;
      dabs2_r <= neg ? 33'(-dot) : 33'(dot);
      for (int k = 0; k < 4; k++) begin
        p2_r[k]   <= p1_r[k];
        pa2_r[k]  <= pa1_r[k];
        qn2_r[k]  <= neg ? -17'(q1_r[k]) : 17'(q1_r[k]);
        qtn2_r[k] <= neg ? -35'(qt1_r[k]) : 35'(qt1_r[k]);
      end
    end
  end

  // stage 3: path test and lerp rounded to q.22
  logic [37:0]        d20;
  logic               lin_c;
  logic signed [35:0] lsum [4];
  logic [35:0]        lmag [4];
  logic [35:0]        lrnd [4];
  logic signed [24:0] l_c  [4];
  always_comb begin
    d20   = 38'(dabs2_r) * 38'd20;
    lin_c = d20 >= (38'd19 << 28);
    for (int k = 0; k < 4; k++) begin
      lsum[k] = 36'(pa2_r[k]) + 36'(qtn2_r[k]);
      lmag[k] = lsum[k][35] ? 36'(-lsum[k]) : 36'(lsum[k]);
      lrnd[k] = (lmag[k] + 36'd128) >> 8;
      l_c[k]  = lsum[k][35] ? (~lrnd[k][24:0] + 25'd1) : lrnd[k][24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3_r    <= t2_r;
      lin3_r  <= lin_c;
      d30_3_r <= {dabs2_r[27:0], 2'b00};
      for (int k = 0; k < 4; k++) begin
        p3_r[k]  <= p2_r[k];
        qn3_r[k] <= qn2_r[k];
        l3_r[k]  <= l_c[k];
      end
    end
  end

  // stage 4: squares for the norm and for the sine
  logic signed [49:0] lsq_c [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lsq_c[k] = l3_r[k] * l3_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t4_r    <= t3_r;
      lin4_r  <= lin3_r;
      d30_4_r <= d30_3_r;
      dsq4_r  <= 60'(d30_3_r) * 60'(d30_3_r);
      for (int k = 0; k < 4; k++) begin
        p4_r[k]   <= p3_r[k];
        qn4_r[k]  <= qn3_r[k];
        l4_r[k]   <= l3_r[k];
        lsq4_r[k] <= lsq_c[k][47:0];
      end
    end
  end

  // squared norm, skip test and radicand selection into the queue
  logic [48:0] n;
  logic [48:0] tol;
  logic [48:0] dev;
  localparam logic [48:0] NORM_ONE = 49'd1 << 44;
  always_comb begin
    n   = 49'(lsq4_r[0]) + 49'(lsq4_r[1]) + 49'(lsq4_r[2]) + 49'(lsq4_r[3]);
    tol = 49'({eps, 20'b0});
    dev = (n > NORM_ONE) ? (n - NORM_ONE) : (NORM_ONE - n);
    push_valid     = v4_r;
    push_item.t    = t4_r;
    push_item.lin  = lin4_r;
    push_item.d30  = d30_4_r;
    push_item.norm = (n > tol) && (dev > tol);
    push_item.rad  = lin4_r ? qs_pkg::RAD_W'(n) :
                     ((qs_pkg::RAD_W'(1) << 60) - qs_pkg::RAD_W'(dsq4_r));
    for (int k = 0; k < 4; k++) begin
      push_item.p[k]  = p4_r[k];
      push_item.qn[k] = qn4_r[k];
      push_item.l[k]  = l4_r[k];
    end
  end

endmodule

>>> rtl/qs_queue.sv
// short queue of classified words between front and back
// uses qs_pkg::item_t
module qs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  qs_pkg::item_t push_item,
  input  logic          pop,
  output logic          valid,
  output logic          full,
  output qs_pkg::item_t head
);

  qs_pkg::item_t              mem_r [qs_pkg::QDEPTH];
  logic [qs_pkg::QAW-1:0]     wr_r, rd_r;
  logic [qs_pkg::QCW-1:0]     cnt_r;

  assign valid = cnt_r != '0;
  assign full  = cnt_r == qs_pkg::QCW'(qs_pkg::QDEPTH);
  assign head  = mem_r[rd_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end

endmodule

>>> rtl/qs_sqrt.sv
// pipelined integer square root, one root bit per stage, word carried alongside
// uses qs_pkg; instantiated by qs_back
module qs_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [qs_pkg::RAD_W-1:0]      in_rad,
  input  qs_pkg::item_t                 in_item,
  output logic                          out_valid,
  output logic [qs_pkg::SQRT_BITS-1:0]  out_root,
  output qs_pkg::item_t                 out_item
);

  localparam int N = qs_pkg::SQRT_BITS;

  logic                          v_r    [N];
  logic [qs_pkg::RAD_W-1:0]      rem_r  [N];
  logic [qs_pkg::SQRT_BITS-1:0]  root_r [N];
  qs_pkg::item_t                 it_r   [N];

  for (genvar j = 0; j < N; j++) begin : g_st
    localparam int B = N - 1 - j;
    logic                          v_i;
    logic [qs_pkg::RAD_W-1:0]      rem_i, trial;
    logic [qs_pkg::SQRT_BITS-1:0]  root_i;
    qs_pkg::item_t                 it_i;

    if (j == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = in_rad;
      assign root_i = '0;
      assign it_i   = in_item;
    end else begin : g_next
      assign v_i    = v_r[j-1];
      assign rem_i  = rem_r[j-1];
      assign root_i = root_r[j-1];
      assign it_i   = it_r[j-1];
    end

    // trial subtract of (2*root + bit) * bit
    assign trial = (qs_pkg::RAD_W'(root_i) << (B + 1)) + (qs_pkg::RAD_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_r[j] <= it_i;
        if (rem_i >= trial) begin
          rem_r[j]  <= rem_i - trial;
          root_r[j] <= root_i | (qs_pkg::SQRT_BITS'(1) << B);
        end else begin
          rem_r[j]  <= rem_i;
          root_r[j] <= root_i;
        end
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_item  = it_r[N-1];

endmodule

>>> rtl/qs_div.sv
// pipelined rounding divider, halves away from zero, one quotient bit per stage
// uses qs_pkg; instantiated four times by qs_back
module qs_div (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [qs_pkg::NUM_W-1:0] num,
  input  logic [qs_pkg::DEN_W-1:0]        den,
  output logic [qs_pkg::DIV_QBITS-1:0]    quo,
  output logic                            neg,
  output logic                            ovf
);

  localparam int S  = qs_pkg::DIV_STAGES;
  localparam int RW = qs_pkg::DIV_REM_W;

  logic [RW-1:0]                rem_r [S];
  logic [qs_pkg::DEN_W-1:0]     den_r [S];
  logic [qs_pkg::DIV_QBITS-1:0] q_r   [S];
  logic                         neg_r [S];
  logic                         ovf_r [S];

  // first stage: magnitude plus half divisor, range check for saturation
  logic [qs_pkg::NUM_W-1:0] mag;
  logic [RW-1:0]            a0;
  always_comb begin
    mag = num[qs_pkg::NUM_W-1] ? qs_pkg::NUM_W'(-num) : qs_pkg::NUM_W'(num);
    a0  = RW'(mag) + RW'(den >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= a0;
      den_r[0] <= den;
      q_r[0]   <= '0;
      neg_r[0] <= num[qs_pkg::NUM_W-1];
      ovf_r[0] <= a0 >= (RW'(den) << qs_pkg::DIV_QBITS);
    end
  end

  // restoring steps, most significant quotient bit first
  for (genvar j = 1; j < S; j++) begin : g_st
    localparam int B = S - 1 - j;
    logic [RW-1:0] trial;
    assign trial = RW'(den_r[j-1]) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[j] <= den_r[j-1];
        neg_r[j] <= neg_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
        if (rem_r[j-1] >= trial) begin
          rem_r[j] <= rem_r[j-1] - trial;
          q_r[j]   <= q_r[j-1] | (qs_pkg::DIV_QBITS'(1) << B);
        end else begin
          rem_r[j] <= rem_r[j-1];
          q_r[j]   <= q_r[j-1];
        end
      end
    end
  end

  assign quo = q_r[S-1];
  assign neg = neg_r[S-1];
  assign ovf = ovf_r[S-1];

endmodule

>>> rtl/qs_back.sv
// back end: shared root, cordic angle and sines, numerator select, dividers, output
// uses qs_pkg, qs_sqrt and qs_div; drains qs_queue
module qs_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  qs_pkg::item_t q_item,
  output logic          q_pop,
  input  logic          out_tready,
  output logic          out_tvalid,
  output logic [63:0]   out_tdata,
  output logic          out_tuser
);

  localparam int T = qs_pkg::TRIG_STAGES;
  localparam int S = qs_pkg::DIV_STAGES;

  logic en;
  logic out_valid_r;
  logic [63:0] out_data_r;
  logic out_user_r;

  // whole back pipeline moves unless the output word is held
  assign en    = !out_valid_r || out_tready;
  assign q_pop = en && q_valid;

  // shared square root: sin(angle) or the lerp norm
  logic                          sq_v;
  logic [qs_pkg::SQRT_BITS-1:0]  sq_root;
  qs_pkg::item_t                 sq_it;

  qs_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (q_valid),
    .in_rad    (q_item.rad),
    .in_item   (q_item),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_item  (sq_it)
  );

  // cordic vectoring: angle = atan2(sin, dot)
  logic                          vv_r  [T];
  logic signed [33:0]            vx_r  [T];
  logic signed [33:0]            vy_r  [T];
  logic signed [33:0]            vz_r  [T];
  qs_pkg::item_t                 vit_r [T];
  logic [qs_pkg::SQRT_BITS-1:0]  vrt_r [T];

  for (genvar i = 0; i < T; i++) begin : g_vec
    logic                          v_i;
    logic signed [33:0]            x_i, y_i, z_i, at;
    qs_pkg::item_t                 it_i;
    logic [qs_pkg::SQRT_BITS-1:0]  rt_i;

    if (i == 0) begin : g_first
      assign v_i  = sq_v;
      assign x_i  = $signed(34'(sq_it.d30));
      assign y_i  = $signed(34'(sq_root));
      assign z_i  = '0;
      assign it_i = sq_it;
      assign rt_i = sq_root;
    end else begin : g_next
      assign v_i  = vv_r[i-1];
      assign x_i  = vx_r[i-1];
      assign y_i  = vy_r[i-1];
      assign z_i  = vz_r[i-1];
      assign it_i = vit_r[i-1];
      assign rt_i = vrt_r[i-1];
    end
    assign at = $signed(34'(qs_pkg::ATAN_Q30[i]));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vv_r[i] <= 1'b0;
      end else if (en) begin
        vv_r[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        vit_r[i] <= it_i;
        vrt_r[i] <= rt_i;
        if (!y_i[33]) begin
          vx_r[i] <= x_i + (y_i >>> i);
          vy_r[i] <= y_i - (x_i >>> i);
          vz_r[i] <= z_i + at;
        end else begin
          vx_r[i] <= x_i - (y_i >>> i);
          vy_r[i] <= y_i + (x_i >>> i);
          vz_r[i] <= z_i - at;
        end
      end
    end
  end

  // angle scaled by (1 - t) and by t, floor shift
  logic                          cv_r;
  qs_pkg::item_t                 cit_r;
  logic [qs_pkg::SQRT_BITS-1:0]  crt_r;
  logic signed [33:0]            ca1_r, ca2_r;
  logic signed [51:0]            a1_full, a2_full;
  logic [16:0]                   om_b;

  always_comb begin
    om_b    = 17'd65536 - vit_r[T-1].t;
    a1_full = vz_r[T-1] * $signed({1'b0, om_b});
    a2_full = vz_r[T-1] * $signed({1'b0, vit_r[T-1].t});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= 1'b0;
    end else if (en) begin
      cv_r <= vv_r[T-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cit_r <= vit_r[T-1];
      crt_r <= vrt_r[T-1];
      ca1_r <= 34'(a1_full >>> 16);
      ca2_r <= 34'(a2_full >>> 16);
    end
  end

  // two cordic rotations side by side: the sine weights
  logic                          rv_r  [T];
  logic signed [33:0]            r1x_r [T];
  logic signed [33:0]            r1y_r [T];
  logic signed [33:0]            r1z_r [T];
  logic signed [33:0]            r2x_r [T];
  logic signed [33:0]            r2y_r [T];
  logic signed [33:0]            r2z_r [T];
  qs_pkg::item_t                 rit_r [T];
  logic [qs_pkg::SQRT_BITS-1:0]  rrt_r [T];

  for (genvar i = 0; i < T; i++) begin : g_rot
    logic                          v_i;
    logic signed [33:0]            x1, y1, z1, x2, y2, z2, at;
    qs_pkg::item_t                 it_i;
    logic [qs_pkg::SQRT_BITS-1:0]  rt_i;

    if (i == 0) begin : g_first
      assign v_i  = cv_r;
      assign x1   = qs_pkg::CORDIC_INV_GAIN;
      assign y1   = '0;
      assign z1   = ca1_r;
      assign x2   = qs_pkg::CORDIC_INV_GAIN;
      assign y2   = '0;
      assign z2   = ca2_r;
      assign it_i = cit_r;
      assign rt_i = crt_r;
    end else begin : g_next
      assign v_i  = rv_r[i-1];
      assign x1   = r1x_r[i-1];
      assign y1   = r1y_r[i-1];
      assign z1   = r1z_r[i-1];
      assign x2   = r2x_r[i-1];
      assign y2   = r2y_r[i-1];
      assign z2   = r2z_r[i-1];
      assign it_i = rit_r[i-1];
      assign rt_i = rrt_r[i-1];
    end
    assign at = $signed(34'(qs_pkg::ATAN_Q30[i]));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_r[i] <= 1'b0;
      end else if (en) begin
        rv_r[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rit_r[i] <= it_i;
        rrt_r[i] <= rt_i;
        if (!z1[33]) begin
          r1x_r[i] <= x1 - (y1 >>> i);
          r1y_r[i] <= y1 + (x1 >>> i);
          r1z_r[i] <= z1 - at;
        end else begin
          r1x_r[i] <= x1 + (y1 >>> i);
          r1y_r[i] <= y1 - (x1 >>> i);
          r1z_r[i] <= z1 + at;
        end
        if (!z2[33]) begin
          r2x_r[i] <= x2 - (y2 >>> i);
          r2y_r[i] <= y2 + (x2 >>> i);
          r2z_r[i] <= z2 - at;
        end else begin
          r2x_r[i] <= x2 + (y2 >>> i);
          r2y_r[i] <= y2 - (x2 >>> i);
          r2z_r[i] <= z2 + at;
        end
      end
    end
  end

  // weighted ends
  logic                          pv_r;
  qs_pkg::item_t                 pit_r;
  logic [qs_pkg::SQRT_BITS-1:0]  prt_r;
  logic signed [47:0]            pr1_r [4];
  logic signed [48:0]            pr2_r [4];
  logic signed [31:0]            w1, w2;

  assign w1 = r1y_r[T-1][31:0];
  assign w2 = r2y_r[T-1][31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= rv_r[T-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pit_r <= rit_r[T-1];
      prt_r <= rrt_r[T-1];
      for (int k = 0; k < 4; k++) begin
        pr1_r[k] <= $signed(rit_r[T-1].p[k]) * w1;
        pr2_r[k] <= $signed(rit_r[T-1].qn[k]) * w2;
      end
    end
  end

  // numerator and divisor for the path taken
  logic                              sv_r, sl_r;
  logic signed [qs_pkg::NUM_W-1:0]   snum_r [4];
  logic [qs_pkg::DEN_W-1:0]          sden_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
    end else if (en) begin
      sv_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sl_r   <= pit_r.lin;
      sden_r <= (pit_r.lin && !pit_r.norm) ? qs_pkg::DEN_W'(256) : prt_r;
      for (int k = 0; k < 4; k++) begin
        if (!pit_r.lin) begin
          snum_r[k] <= qs_pkg::NUM_W'(pr1_r[k]) + qs_pkg::NUM_W'(pr2_r[k]);
        end else if (pit_r.norm) begin
          snum_r[k] <= qs_pkg::NUM_W'($signed(pit_r.l[k])) <<< 14;
        end else begin
          snum_r[k] <= qs_pkg::NUM_W'($signed(pit_r.l[k]));
        end
      end
    end
  end

  // four dividers with valid and path flag alongside
  logic [qs_pkg::DIV_QBITS-1:0] dq   [4];
  logic                         dneg [4];
  logic                         dovf [4];
  logic                         dv_r [S];
  logic                         dl_r [S];

  for (genvar k = 0; k < 4; k++) begin : g_div
    qs_div u_div (
      .clk (clk),
      .en  (en),
      .num (snum_r[k]),
      .den (sden_r),
      .quo (dq[k]),
      .neg (dneg[k]),
      .ovf (dovf[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < S; j++) dv_r[j] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= sv_r;
      for (int j = 1; j < S; j++) dv_r[j] <= dv_r[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= sl_r;
      for (int j = 1; j < S; j++) dl_r[j] <= dl_r[j-1];
    end
  end

  // saturate to q1.14 and hold in the output register
  logic [15:0] res [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (dneg[k]) begin
        if (dovf[k] || dq[k] > 17'd32768) res[k] = 16'h8000;
        else res[k] = ~dq[k][15:0] + 16'd1;
      end else begin
        if (dovf[k] || dq[k] > 17'd32767) res[k] = 16'h7FFF;
        else res[k] = dq[k][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[S-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {res[3], res[2], res[1], res[0]};
      out_user_r <= dl_r[S-1];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> test/tb_quaternion_slerp_top.sv
// self-checking testbench for the quaternion interpolation block
// depends on qs_pkg (cordic table, gain and depth) and quaternion_slerp_top
module tb_quaternion_slerp_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] res [4];
    logic        lin;
  } slerp_word_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [151:0] in_tdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  out_tdata;
  logic         out_tuser;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  localparam logic [2:0] ADDR_EPSILON = 3'd0;
  localparam int         DRAIN_CYCLES = 120;

  logic [151:0]  pending_words [$];
  slerp_word_t   expected_words [$];
  logic [15:0]   eps_model = 16'd168;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            hold_gen = 0;
  int            mismatches = 0;
  int            n_sph = 0;
  int            n_lin = 0;
  logic          in_acc = 1'b0;

  quaternion_slerp_top i_dut (
    .clk, .rst_n, .in_tdata, .in_tvalid, .in_tready, .out_tdata, .out_tuser,
    .out_tvalid, .out_tready, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // arithmetic helpers for the interpolation predictor
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint div_round(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic longint angle_of(longint y, longint x);
    longint z, xs, ys;
    z = 0;
    for (int i = 0; i < qs_pkg::TRIG_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(qs_pkg::ATAN_Q30[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(qs_pkg::ATAN_Q30[i]);
      end
    end
    return z;
  endfunction

  function automatic longint sine_of(longint z);
    longint x, y, xs, ys;
    x = longint'(qs_pkg::CORDIC_INV_GAIN);
    y = 0;
    for (int i = 0; i < qs_pkg::TRIG_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(qs_pkg::ATAN_Q30[i]);
      end else begin
        x += ys; y -= xs; z += longint'(qs_pkg::ATAN_Q30[i]);
      end
    end
    return y;
  endfunction

  // expected result word for one request word
  function automatic slerp_word_t interpolate(logic [151:0] d, logic [15:0] eps);
    slerp_word_t e;
    longint p [4], q [4], l [4];
    longint dot, t, d30, s30, ang, w1, w2, m;
    longint unsigned n, tol, one, dev;
    dot = 0;
    for (int k = 0; k < 4; k++) begin
      p[k] = longint'($signed(d[16*k +: 16]));
      q[k] = longint'($signed(d[64 + 16*k +: 16]));
      dot += p[k] * q[k];
    end
    t = longint'(d[144:128]);
    if (t > 65536) t = 65536;
    if (dot < 0) begin
      dot = -dot;
      for (int k = 0; k < 4; k++) q[k] = -q[k];
    end
    e.lin = !(dot * 20 < (longint'(19) << 28));
    if (!e.lin) begin
      d30 = dot << 2;
      s30 = longint'(int_sqrt((64'd1 << 60) - longint'(d30 * d30)));
      ang = angle_of(s30, d30);
      w1 = sine_of((ang * (65536 - t)) >>> 16);
      w2 = sine_of((ang * t) >>> 16);
      for (int k = 0; k < 4; k++) e.res[k] = clamp16(div_round(p[k] * w1 + q[k] * w2, s30));
    end else begin
      n = 0;
      tol = longint'(eps) << 20;
      one = 64'd1 << 44;
      for (int k = 0; k < 4; k++) begin
        l[k] = div_round(p[k] * (65536 - t) + q[k] * t, 256);
        n += l[k] * l[k];
      end
      dev = (n > one) ? n - one : one - n;
      if (n > tol && dev > tol) begin
        m = longint'(int_sqrt(n));
        for (int k = 0; k < 4; k++) e.res[k] = clamp16(div_round(l[k] * 16384, m));
      end else begin
        for (int k = 0; k < 4; k++) e.res[k] = clamp16(div_round(l[k], 256));
      end
    end
    return e;
  endfunction

  function automatic logic [151:0] pack_req(longint f [4], longint g [4], logic [16:0] t);
    logic [151:0] w;
    w = '0;
    for (int k = 0; k < 4; k++) begin
      w[16*k +: 16] = f[k][15:0];
      w[64 + 16*k +: 16] = g[k][15:0];
    end
    w[144:128] = t;
    return w;
  endfunction

  // random near-unit quaternion in q1.14
  task automatic unit_quat(output longint v [4]);
    real c [4];
    real s;
    s = 1e-9;
    for (int k = 0; k < 4; k++) begin
      c[k] = real'(int'($urandom_range(0, 32768)) - 16384);
      s += c[k] * c[k];
    end
    s = $sqrt(s);
    for (int k = 0; k < 4; k++) v[k] = longint'($rtoi(c[k] * 16384.0 / s));
  endtask

  task automatic random_req(output logic [151:0] w);
    longint f [4], g [4];
    logic [16:0] t;
    int kind, spread;
    kind = $urandom_range(0, 9);
    t = ($urandom_range(0, 7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    if (kind < 2) begin
      w = 152'({$urandom, $urandom, $urandom, $urandom, $urandom});
      w[151:145] = '0;
      w[144:128] = t;
    end else begin
      unit_quat(f);
      if (kind < 7) begin
        // target close to the start: mostly the linear path
        spread = (kind < 4) ? 300 : ((kind < 6) ? 3000 : 9000);
        for (int k = 0; k < 4; k++) begin
          g[k] = f[k] + $urandom_range(0, 2 * spread) - spread;
          if (g[k] > 32767) g[k] = 32767;
          if (g[k] < -32768) g[k] = -32768;
        end
        if ($urandom_range(0, 1)) for (int k = 0; k < 4; k++) g[k] = -g[k];
      end else begin
        unit_quat(g);
      end
      w = pack_req(f, g, t);
    end
  endtask

  // register write over the apb port, idle block only
  task automatic write_epsilon(logic [15:0] v);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_penable = 1'b0;
    cfg_paddr = ADDR_EPSILON; cfg_pwdata = {16'd0, v};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    eps_model = v;
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic drain;
    while (pending_words.size() != 0 || expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // handshake sampling, prediction and checking at the rising edge
  always @(posedge clk) begin
    slerp_word_t e;
    in_acc <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) expected_words.push_back(interpolate(in_tdata, eps_model));
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", out_tdata));
      end else begin
        e = expected_words.pop_front();
        if (e.lin) n_lin++; else n_sph++;
        for (int k = 0; k < 4; k++)
          if (out_tdata[16*k +: 16] !== e.res[k])
            report_mismatch($sformatf("component %0d got %h want %h", k,
                                      out_tdata[16*k +: 16], e.res[k]));
        if (out_tuser !== e.lin)
          report_mismatch($sformatf("linear flag got %b want %b", out_tuser, e.lin));
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_acc)) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tdata <= pending_words.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with an occasional long hold-off
  int hold_left = 0;
  int hold_seen = 0;
  always @(negedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    #2ms;
    $display("[quaternion_slerp_top] ERROR");
    $finish;
  end

  initial begin
    longint f [4], g [4], z [4];
    logic [151:0] w;
    int eps_sel [4];
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed words at the reset tolerance
    z = '{0, 0, 0, 0};
    f = '{0, 0, 0, 16384};
    g = '{16384, 0, 0, 0};
    pending_words.push_back(pack_req(z, z, 17'd32768));
    pending_words.push_back(pack_req(f, f, 17'd0));
    pending_words.push_back(pack_req(f, f, 17'd65536));
    pending_words.push_back(pack_req(f, g, 17'd0));
    pending_words.push_back(pack_req(f, g, 17'd65536));
    pending_words.push_back(pack_req(f, g, 17'd32768));
    pending_words.push_back(pack_req(f, g, 17'h1FFFF));
    pending_words.push_back(pack_req(f, g, 17'd65537));
    g = '{0, 0, 0, -16384};
    pending_words.push_back(pack_req(f, g, 17'd20000));
    g = '{0, 0, 3000, 16100};
    pending_words.push_back(pack_req(f, g, 17'd30000));
    g = '{0, 0, -3000, -16100};
    pending_words.push_back(pack_req(f, g, 17'd45000));
    f = '{32767, 32767, 32767, 32767};
    pending_words.push_back(pack_req(f, f, 17'd12345));
    g = '{-32768, -32768, -32768, -32768};
    pending_words.push_back(pack_req(f, g, 17'd54321));
    pending_words.push_back(pack_req(g, g, 17'd65536));
    f = '{32767, -32768, 32767, -32768};
    g = '{-32768, 32767, -32768, 32767};
    pending_words.push_back(pack_req(f, g, 17'd1));
    f = '{8192, 8192, 8192, 8192};
    g = '{8192, 8192, 8192, 8193};
    pending_words.push_back(pack_req(f, g, 17'd40000));
    f = '{100, 0, 0, 0};
    pending_words.push_back(pack_req(f, f, 17'd5000));
    f = '{0, 11585, 0, 11585};
    g = '{0, 11585, 0, 11586};
    pending_words.push_back(pack_req(f, g, 17'd65535));
    drain();

    // random phases, each with its own tolerance and idling mix
    eps_sel = '{0, 65535, 1 + $urandom_range(0, 4000), 168};
    for (int ph = 0; ph < 4; ph++) begin
      write_epsilon(eps_sel[ph][15:0]);
      case (ph)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 64; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 64; end
        default: begin send_idle_pct = 10; recv_idle_pct = 10; end
      endcase
      if (ph == 0 || ph == 3) hold_gen++;
      for (int i = 0; i < 125; i++) begin
        random_req(w);
        pending_words.push_back(w);
      end
      drain();
    end

    foreach (expected_words[i]) report_mismatch("expected word never arrived");
    $display("checked %0d spherical and %0d linear results", n_sph, n_lin);
    $display("four tolerance settings, idling mixes and a long receiver stall");
    if (mismatches == 0) begin
      $display("[quaternion_slerp_top] OK");
    end else begin
      $display("[quaternion_slerp_top] ERROR");
    end
    $finish;
  end

endmodule

>>> quaternion_slerp_top.f
rtl/qs_pkg.sv
rtl/qs_front.sv
rtl/qs_queue.sv
rtl/qs_sqrt.sv
rtl/qs_div.sv
rtl/qs_back.sv
rtl/quaternion_slerp_top.sv
test/tb_quaternion_slerp_top.sv
